### src/tsdbp_pkg.sv
// shared types and constants for the descriptor byte parser
package tsdbp_pkg;

  typedef logic [3:0] kind_t;
  typedef logic [3:0] phase_t;

  localparam kind_t KIND_TAG        = 4'd0;
  localparam kind_t KIND_LEN_OK     = 4'd1;
  localparam kind_t KIND_OVERSIZE   = 4'd2;
  localparam kind_t KIND_SUBT_ERR   = 4'd3;
  localparam kind_t KIND_SVC_TYPE   = 4'd4;
  localparam kind_t KIND_PROV_LEN   = 4'd5;
  localparam kind_t KIND_PROV_BYTE  = 4'd6;
  localparam kind_t KIND_NAME_LEN   = 4'd7;
  localparam kind_t KIND_NAME_BYTE  = 4'd8;
  localparam kind_t KIND_ENTRY_PART = 4'd9;
  localparam kind_t KIND_ENTRY_DONE = 4'd10;
  localparam kind_t KIND_RAW        = 4'd11;
  localparam kind_t KIND_IGNORED    = 4'd12;

  localparam phase_t PH_IDLE       = 4'd0;
  localparam phase_t PH_LEN        = 4'd1;
  localparam phase_t PH_SVC_TYPE   = 4'd2;
  localparam phase_t PH_PROV_LEN   = 4'd3;
  localparam phase_t PH_PROV_BYTES = 4'd4;
  localparam phase_t PH_NAME_LEN   = 4'd5;
  localparam phase_t PH_NAME_BYTES = 4'd6;
  localparam phase_t PH_SUBT       = 4'd7;
  localparam phase_t PH_RAW        = 4'd8;
  localparam phase_t PH_TRAIL      = 4'd9;

  localparam logic [7:0] SVC_TAG_RESET  = 8'h48;
  localparam logic [7:0] SUBT_TAG_RESET = 8'h59;

  localparam logic [2:0] ADDR_SVC_TAG  = 3'd0;
  localparam logic [2:0] ADDR_SUBT_TAG = 3'd4;

endpackage

### src/ts_descriptor_byte_parser_top.sv
// descriptor loop byte parser: one classified result per input byte
//
// input channel: in_valid / in_stall carry one loop byte per transaction, with
// in_is_first marking a tag byte and in_space_left giving the loop space then.
// output channel: out_valid / out_stall carry one result per input byte.
// the byte is held in an input register, then parsed by the phase logic into
// the result register.
// throughput is one byte per cycle; the input register and result register
// both advance whenever the result register is empty or being taken.
// when the receiver stalls, the result register holds, the input register
// fills and in_stall rises until the result is taken; nothing is dropped.
// the apb port holds the service and subtitling tag registers at byte
// addresses 0 and 4; pready is always high.
// reset (rst_n low, synchronous) empties both registers, returns the parser
// to idle with cleared descriptor state and loads the tag registers with
// 0x48 and 0x59.
module ts_descriptor_byte_parser_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte_in,
  input  logic                 in_is_first,
  input  logic [11:0]          in_space_left,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tsdbp_pkg::kind_t     out_kind,
  output logic [7:0]           out_desc_tag,
  output logic [7:0]           out_desc_len,
  output logic [7:0]           out_item_index,
  output logic [7:0]           out_byte_value,
  output logic [23:0]          out_language_code,
  output logic [7:0]           out_sub_type,
  output logic [15:0]          out_composition_page,
  output logic [15:0]          out_ancillary_page,
  output logic                 out_last
);
  import tsdbp_pkg::*;

  logic [7:0]  svc_tag_r, subt_tag_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_first_r;
  logic [11:0] s1_space_r;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_tag_r, out_len_r, out_item_r, out_bval_r, out_stype_r;
  logic [23:0] out_lang_r;
  logic [15:0] out_comp_r, out_anc_r;
  logic        out_last_r;

  phase_t      ph_r, ph_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [11:0] space_r, space_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [55:0] shift_r, shift_nxt;
  logic [7:0]  nleft_r, nleft_nxt;

  kind_t       res_kind;
  logic [7:0]  res_item, res_bval, res_stype;
  logic [23:0] res_lang;
  logic [15:0] res_comp, res_anc;
  logic        res_last;

  logic        advance, move;
  logic        is_svc, is_subt;
  logic [7:0]  consumed;
  logic        cfg_wr;

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {24'd0, paddr[2] ? subt_tag_r : svc_tag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svc_tag_r  <= SVC_TAG_RESET;
      subt_tag_r <= SUBT_TAG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_SUBT_TAG[2]) begin
        subt_tag_r <= pwdata[7:0];
      end else begin
        svc_tag_r <= pwdata[7:0];
      end
    end
  end

  // handshake
  assign advance  = !out_valid_r || !out_stall;
  assign move     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r  <= in_byte_in;
      s1_first_r <= in_is_first;
      s1_space_r <= in_space_left;
    end
  end

  // parse logic
  assign is_svc   = (tag_r == svc_tag_r);
  assign is_subt  = (tag_r == subt_tag_r);
  assign consumed = len_r - rem_r;

  always_comb begin
    ph_nxt    = ph_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    space_nxt = space_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    nleft_nxt = nleft_r;
    res_kind  = KIND_IGNORED;
    res_item  = 8'd0;
    res_bval  = 8'd0;
    res_stype = 8'd0;
    res_lang  = 24'd0;
    res_comp  = 16'd0;
    res_anc   = 16'd0;
    res_last  = 1'b0;
    if (s1_first_r) begin
      tag_nxt   = s1_byte_r;
      len_nxt   = 8'd0;
      space_nxt = s1_space_r;
      rem_nxt   = 8'd0;
      idx_nxt   = 8'd0;
      shift_nxt = 56'd0;
      nleft_nxt = 8'd0;
      ph_nxt    = PH_LEN;
      res_kind  = KIND_TAG;
      res_bval  = s1_byte_r;
    end else if (ph_r == PH_IDLE) begin
      res_kind = KIND_IGNORED;
    end else if (ph_r == PH_LEN) begin
      len_nxt  = s1_byte_r;
      res_bval = s1_byte_r;
      if (({4'd0, s1_byte_r} + 12'd2) > space_r) begin
        res_kind = KIND_OVERSIZE;
        res_last = 1'b1;
        ph_nxt   = PH_IDLE;
      end else if (!is_svc && is_subt && (s1_byte_r[2:0] != 3'd0)) begin
        res_kind = KIND_SUBT_ERR;
        res_last = 1'b1;
        ph_nxt   = PH_IDLE;
      end else begin
        res_kind  = KIND_LEN_OK;
        rem_nxt   = s1_byte_r;
        idx_nxt   = 8'd0;
        shift_nxt = 56'd0;
        if (s1_byte_r == 8'd0) begin
          res_last = 1'b1;
          ph_nxt   = PH_IDLE;
        end else if (is_svc) begin
          ph_nxt = PH_SVC_TYPE;
        end else if (is_subt) begin
          ph_nxt = PH_SUBT;
        end else begin
          ph_nxt = PH_RAW;
        end
      end
    end else begin
      res_bval = s1_byte_r;
      case (ph_r)
        PH_SVC_TYPE: begin
          res_kind = KIND_SVC_TYPE;
          ph_nxt   = PH_PROV_LEN;
        end
        PH_PROV_LEN: begin
          res_kind  = KIND_PROV_LEN;
          nleft_nxt = s1_byte_r;
          idx_nxt   = 8'd0;
          ph_nxt    = (s1_byte_r != 8'd0) ? PH_PROV_BYTES : PH_NAME_LEN;
        end
        PH_PROV_BYTES: begin
          res_kind  = KIND_PROV_BYTE;
          res_item  = idx_r;
          idx_nxt   = idx_r + 8'd1;
          nleft_nxt = nleft_r - 8'd1;
          if (nleft_r == 8'd1) begin
            ph_nxt = PH_NAME_LEN;
          end
        end
        PH_NAME_LEN: begin
          res_kind  = KIND_NAME_LEN;
          nleft_nxt = s1_byte_r;
          idx_nxt   = 8'd0;
          ph_nxt    = (s1_byte_r != 8'd0) ? PH_NAME_BYTES : PH_TRAIL;
        end
        PH_NAME_BYTES: begin
          res_kind  = KIND_NAME_BYTE;
          res_item  = idx_r;
          idx_nxt   = idx_r + 8'd1;
          nleft_nxt = nleft_r - 8'd1;
          if (nleft_r == 8'd1) begin
            ph_nxt  = PH_TRAIL;
            idx_nxt = 8'd0;
          end
        end
        PH_SUBT: begin
          res_item = {3'd0, consumed[7:3]};
          idx_nxt  = {3'd0, consumed[7:3]};
          res_bval = 8'd0;
          if (consumed[2:0] != 3'd7) begin
            res_kind  = KIND_ENTRY_PART;
            shift_nxt = {shift_r[47:0], s1_byte_r};
          end else begin
            res_kind  = KIND_ENTRY_DONE;
            res_lang  = shift_r[55:32];
            res_stype = shift_r[31:24];
            res_comp  = shift_r[23:8];
            res_anc   = {shift_r[7:0], s1_byte_r};
            shift_nxt = 56'd0;
          end
        end
        default: begin
          res_kind = KIND_RAW;
          res_item = idx_r;
          idx_nxt  = idx_r + 8'd1;
        end
      endcase
      rem_nxt = rem_r - 8'd1;
      if (rem_r == 8'd1) begin
        res_last = 1'b1;
        ph_nxt   = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_IDLE;
      tag_r   <= 8'd0;
      len_r   <= 8'd0;
      space_r <= 12'd0;
      rem_r   <= 8'd0;
      idx_r   <= 8'd0;
      shift_r <= 56'd0;
      nleft_r <= 8'd0;
    end else if (move) begin
      ph_r    <= ph_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      space_r <= space_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
      nleft_r <= nleft_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_kind_r  <= res_kind;
      out_tag_r   <= tag_nxt;
      out_len_r   <= len_nxt;
      out_item_r  <= res_item;
      out_bval_r  <= res_bval;
      out_lang_r  <= res_lang;
      out_stype_r <= res_stype;
      out_comp_r  <= res_comp;
      out_anc_r   <= res_anc;
      out_last_r  <= res_last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = out_kind_r;
  assign out_desc_tag          = out_tag_r;
  assign out_desc_len          = out_len_r;
  assign out_item_index        = out_item_r;
  assign out_byte_value        = out_bval_r;
  assign out_language_code     = out_lang_r;
  assign out_sub_type          = out_stype_r;
  assign out_composition_page  = out_comp_r;
  assign out_ancillary_page    = out_anc_r;
  assign out_last              = out_last_r;

endmodule

### sim/tb.sv
// testbench for the descriptor loop byte parser: directed and random loops, predicted and checked
`timescale 1ns / 100ps

module tb;
  import tsdbp_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tag;
    logic [7:0]  length;
    logic [7:0]  index;
    logic [7:0]  value;
    logic [23:0] lang;
    logic [7:0]  stype;
    logic [15:0] comp;
    logic [15:0] anc;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_in = '0;
  logic        in_is_first = 1'b0;
  logic [11:0] in_space_left = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       out_kind;
  logic [7:0]  out_desc_tag;
  logic [7:0]  out_desc_len;
  logic [7:0]  out_item_index;
  logic [7:0]  out_byte_value;
  logic [23:0] out_language_code;
  logic [7:0]  out_sub_type;
  logic [15:0] out_composition_page;
  logic [15:0] out_ancillary_page;
  logic        out_last;

  // parser state and tag registers as predicted
  logic [7:0]  svc_tag_cfg = SVC_TAG_RESET;
  logic [7:0]  subt_tag_cfg = SUBT_TAG_RESET;
  phase_t      st_phase = PH_IDLE;
  logic [7:0]  st_tag = '0;
  logic [7:0]  st_len = '0;
  logic [11:0] st_room = '0;
  logic [7:0]  st_left = '0;
  logic [7:0]  st_index = '0;
  logic [55:0] st_entry = '0;
  logic [7:0]  st_name_cnt = '0;

  result_t     pending_results[$];
  int          error_count = 0;
  int          checked_count = 0;
  int          sent_count = 0;
  int          burst_left = 0;
  int          stall_run = 0;
  int          stall_pct = 0;
  int          idle_cycles = 0;
  bit          gaps_on = 1'b0;

  ts_descriptor_byte_parser_top u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_byte_in            (in_byte_in),
    .in_is_first           (in_is_first),
    .in_space_left         (in_space_left),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_kind              (out_kind),
    .out_desc_tag          (out_desc_tag),
    .out_desc_len          (out_desc_len),
    .out_item_index        (out_item_index),
    .out_byte_value        (out_byte_value),
    .out_language_code     (out_language_code),
    .out_sub_type          (out_sub_type),
    .out_composition_page  (out_composition_page),
    .out_ancillary_page    (out_ancillary_page),
    .out_last              (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t classify_byte(input logic [7:0] b, input logic first,
                                            input logic [11:0] room);
    result_t    r;
    logic [7:0] consumed;
    r = '0;
    r.kind = KIND_IGNORED;
    if (first) begin
      st_tag = b;
      st_len = '0;
      st_room = room;
      st_left = '0;
      st_index = '0;
      st_entry = '0;
      st_name_cnt = '0;
      st_phase = PH_LEN;
      r.kind = KIND_TAG;
      r.value = b;
    end else if (st_phase == PH_IDLE) begin
      r.kind = KIND_IGNORED;
    end else if (st_phase == PH_LEN) begin
      st_len = b;
      r.value = b;
      if ({4'd0, b} + 12'd2 > st_room) begin
        r.kind = KIND_OVERSIZE;
        r.last = 1'b1;
        st_phase = PH_IDLE;
      end else if (st_tag != svc_tag_cfg && st_tag == subt_tag_cfg && b[2:0] != 3'd0) begin
        r.kind = KIND_SUBT_ERR;
        r.last = 1'b1;
        st_phase = PH_IDLE;
      end else begin
        r.kind = KIND_LEN_OK;
        st_left = b;
        st_index = '0;
        st_entry = '0;
        if (b == 8'd0) begin
          r.last = 1'b1;
          st_phase = PH_IDLE;
        end else if (st_tag == svc_tag_cfg) begin
          st_phase = PH_SVC_TYPE;
        end else if (st_tag == subt_tag_cfg) begin
          st_phase = PH_SUBT;
        end else begin
          st_phase = PH_RAW;
        end
      end
    end else begin
      consumed = st_len - st_left;
      r.value = b;
      case (st_phase)
        PH_SVC_TYPE: begin
          r.kind = KIND_SVC_TYPE;
          st_phase = PH_PROV_LEN;
        end
        PH_PROV_LEN: begin
          r.kind = KIND_PROV_LEN;
          st_name_cnt = b;
          st_index = '0;
          st_phase = (b != 8'd0) ? PH_PROV_BYTES : PH_NAME_LEN;
        end
        PH_PROV_BYTES: begin
          r.kind = KIND_PROV_BYTE;
          r.index = st_index;
          st_index = st_index + 8'd1;
          st_name_cnt = st_name_cnt - 8'd1;
          if (st_name_cnt == 8'd0) st_phase = PH_NAME_LEN;
        end
        PH_NAME_LEN: begin
          r.kind = KIND_NAME_LEN;
          st_name_cnt = b;
          st_index = '0;
          st_phase = (b != 8'd0) ? PH_NAME_BYTES : PH_TRAIL;
        end
        PH_NAME_BYTES: begin
          r.kind = KIND_NAME_BYTE;
          r.index = st_index;
          st_index = st_index + 8'd1;
          st_name_cnt = st_name_cnt - 8'd1;
          if (st_name_cnt == 8'd0) begin
            st_phase = PH_TRAIL;
            st_index = '0;
          end
        end
        PH_SUBT: begin
          r.index = consumed >> 3;
          st_index = consumed >> 3;
          r.value = '0;
          if (consumed[2:0] != 3'd7) begin
            r.kind = KIND_ENTRY_PART;
            st_entry = {st_entry[47:0], b};
          end else begin
            r.kind = KIND_ENTRY_DONE;
            r.lang = st_entry[55:32];
            r.stype = st_entry[31:24];
            r.comp = st_entry[23:8];
            r.anc = {st_entry[7:0], b};
            st_entry = '0;
          end
        end
        default: begin
          r.kind = KIND_RAW;
          r.index = st_index;
          st_index = st_index + 8'd1;
        end
      endcase
      st_left = st_left - 8'd1;
      if (st_left == 8'd0) begin
        r.last = 1'b1;
        st_phase = PH_IDLE;
      end
    end
    r.tag = st_tag;
    r.length = st_len;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    error_count++;
    if (error_count <= 50)
      $display("%0t: result %0d %s: got %0h, expected %0h", $time, checked_count, what, got,
               want);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input logic [11:0] room);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on) begin
        repeat (($urandom_range(3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4)) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte_in <= b;
    in_is_first <= first;
    in_space_left <= room;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(classify_byte(b, first, room));
    sent_count++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tag(input logic [2:0] addr, input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {24'($urandom_range(24'hFFFFFF)), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    if (prdata !== {24'd0, value})
      report_mismatch("tag readback", prdata[23:0], {16'd0, value});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_SVC_TAG) svc_tag_cfg = value;
    else subt_tag_cfg = value;
  endtask

  task automatic set_tags(input logic [7:0] svc, input logic [7:0] subt);
    wait_idle();
    write_tag(ADDR_SVC_TAG, svc);
    write_tag(ADDR_SUBT_TAG, subt);
  endtask

  // mostly well-formed descriptors; some oversize, bad lengths, cut short or followed by noise
  task automatic send_descriptor();
    logic [7:0]  body[$];
    logic [7:0]  tag;
    logic [7:0]  len;
    logic [11:0] room;
    int          n;
    int          pick;
    int          i;
    pick = $urandom_range(9);
    if (pick < 3) tag = svc_tag_cfg;
    else if (pick < 6) tag = subt_tag_cfg;
    else tag = 8'($urandom_range(255));
    if (tag == svc_tag_cfg) begin
      body.push_back(8'($urandom_range(255)));
      n = $urandom_range(6);
      body.push_back(n[7:0]);
      repeat (n) body.push_back(8'($urandom_range(255)));
      n = $urandom_range(8);
      body.push_back(n[7:0]);
      repeat (n) body.push_back(8'($urandom_range(255)));
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(255)));
    end else if (tag == subt_tag_cfg) begin
      repeat (8 * $urandom_range(3)) body.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(10)) body.push_back(8'($urandom_range(255)));
    end
    len = 8'(body.size());
    pick = $urandom_range(29);
    if (pick == 0) len = 8'hFF;
    else if (pick < 3) len = 8'($urandom_range(255));
    else if (pick < 5 && len != 8'd0) len = 8'($urandom_range(len - 1));
    while (body.size() < len) body.push_back(8'($urandom_range(255)));
    pick = $urandom_range(9);
    if (pick == 0) room = 12'($urandom_range(len + 1));
    else if (pick == 1) room = 12'(len) + 12'd2;
    else room = 12'($urandom_range(len + 2, 4095));
    n = len + 1;
    if ($urandom_range(11) == 0) n = $urandom_range(len);
    send_byte(tag, 1'b1, room);
    for (i = 0; i < n; i++)
      send_byte((i == 0) ? len : body[i - 1], 1'b0, 12'($urandom_range(4095)));
    if ($urandom_range(5) == 0)
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom_range(255)), 1'b0, 12'($urandom_range(4095)));
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = sent_count + count;
    while (sent_count < goal) send_descriptor();
  endtask

  task automatic test_directed_cases();
    gaps_on = 1'b0;
    stall_pct = 0;
    send_byte(8'hFF, 1'b0, 12'hFFF);
    send_byte(8'h00, 1'b1, 12'h000);
    send_byte(8'hFF, 1'b0, 12'h000);
    send_byte(8'h11, 1'b1, 12'd2);
    send_byte(8'h00, 1'b0, 12'h000);
    send_byte(svc_tag_cfg, 1'b1, 12'hFFF);
    send_byte(8'd5, 1'b0, 12'hFFF);
    send_byte(8'h19, 1'b0, 12'h000);
    send_byte(8'd1, 1'b0, 12'hFFF);
    send_byte(8'h41, 1'b0, 12'h000);
    send_byte(8'd0, 1'b0, 12'hFFF);
    send_byte(8'hFF, 1'b0, 12'h000);
    // service fields cut off by the declared length
    send_byte(svc_tag_cfg, 1'b1, 12'd4);
    send_byte(8'd2, 1'b0, 12'h000);
    send_byte(8'h01, 1'b0, 12'h000);
    send_byte(8'hFF, 1'b0, 12'h000);
    send_byte(subt_tag_cfg, 1'b1, 12'd9);
    send_byte(8'd7, 1'b0, 12'h000);
    // raw descriptor abandoned by a new tag
    send_byte(8'hFE, 1'b1, 12'hFFF);
    send_byte(8'h80, 1'b0, 12'h000);
    send_byte(8'h00, 1'b0, 12'h000);
    send_byte(subt_tag_cfg, 1'b1, 12'd10);
    send_byte(8'd8, 1'b0, 12'h000);
    send_byte(8'h65, 1'b0, 12'h000);
    send_byte(8'h6E, 1'b0, 12'h000);
    send_byte(8'h67, 1'b0, 12'h000);
    send_byte(8'h10, 1'b0, 12'h000);
    send_byte(8'h00, 1'b0, 12'h000);
    send_byte(8'h01, 1'b0, 12'h000);
    send_byte(8'hFF, 1'b0, 12'h000);
    send_byte(8'hFF, 1'b0, 12'h000);
  endtask

  task automatic test_default_tags();
    gaps_on = 1'b1;
    stall_pct = 30;
    run_random(500);
  endtask

  task automatic test_equal_tags();
    logic [7:0] shared;
    shared = 8'($urandom_range(255));
    set_tags(shared, shared);
    gaps_on = 1'b1;
    stall_pct = 20;
    run_random(400);
  endtask

  task automatic test_extreme_tags();
    set_tags(8'hFF, 8'h00);
    gaps_on = 1'b1;
    stall_pct = 40;
    run_random(300);
    set_tags(8'h00, 8'hFF);
    run_random(300);
  endtask

  task automatic test_random_tags();
    set_tags(8'($urandom_range(255)), 8'($urandom_range(255)));
    gaps_on = 1'b0;
    stall_pct = 0;
    run_random(200);
    gaps_on = 1'b1;
    stall_pct = 60;
    run_random(200);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_default_tags();
    test_equal_tags();
    test_extreme_tags();
    test_random_tags();
    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      if ($urandom_range(31) == 0) stall_run = $urandom_range(5, 25);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_kind;
      got.tag = out_desc_tag;
      got.length = out_desc_len;
      got.index = out_item_index;
      got.value = out_byte_value;
      got.lang = out_language_code;
      got.stype = out_sub_type;
      got.comp = out_composition_page;
      got.anc = out_ancillary_page;
      got.last = out_last;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 24'(got.kind), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("kind", 24'(got.kind), 24'(want.kind));
        if (got.tag !== want.tag)
          report_mismatch("desc_tag", 24'(got.tag), 24'(want.tag));
        if (got.length !== want.length)
          report_mismatch("desc_len", 24'(got.length), 24'(want.length));
        if (got.index !== want.index)
          report_mismatch("item_index", 24'(got.index), 24'(want.index));
        if (got.value !== want.value)
          report_mismatch("byte_value", 24'(got.value), 24'(want.value));
        if (got.lang !== want.lang) report_mismatch("language_code", got.lang, want.lang);
        if (got.stype !== want.stype)
          report_mismatch("sub_type", 24'(got.stype), 24'(want.stype));
        if (got.comp !== want.comp)
          report_mismatch("composition_page", 24'(got.comp), 24'(want.comp));
        if (got.anc !== want.anc)
          report_mismatch("ancillary_page", 24'(got.anc), 24'(want.anc));
        if (got.last !== want.last)
          report_mismatch("last", 24'(got.last), 24'(want.last));
      end
      checked_count++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
